>>> hw/rtl/cpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cpa_pkg;

  // Field widths
  localparam int CW  = 24;   // coordinates, Q15.8
  localparam int VW  = 16;   // velocities, Q7.8
  localparam int AGW = 16;   // track age, Q8.8
  localparam int RDW = 16;   // radii, Q8.8
  localparam int SCW = 10;   // radius scale, Q2.8
  localparam int HZW = 16;   // horizon, Q8.8
  localparam int TQW = 24;   // time to CPA output
  localparam int QB  = 24;   // quotient and root bits

  // Internal widths
  localparam int UW   = VW + 1;
  localparam int PW   = VW + AGW + 1;
  localparam int ESW  = ((CW > PW - 8) ? CW : PW - 8) + 1;
  localparam int RW   = CW + 1;
  localparam int SW   = 2 * UW;
  localparam int LSW  = RDW + 1;
  localparam int LW   = SCW + LSW;
  localparam int L2W  = 2 * LW;
  localparam int LPW  = LW + SW;
  localparam int LSPW = L2W + SW;
  localparam int RRW  = 2 * RW;
  localparam int D2W  = 2 * CW + 2;
  localparam int DTW  = RW + UW;
  localparam int AW   = DTW - 1;
  localparam int AH   = (AW + 1) / 2;
  localparam int NMW  = AW + 8;
  localparam int NW   = ((NMW + 1 > SW) ? NMW + 1 : SW) + 1;
  localparam int DVW  = SW + 1;
  localparam int QRW  = (NW > DVW + QB - 1) ? NW : DVW + QB - 1;
  localparam int TW   = (2 * AW > D2W) ? 2 * AW : D2W;
  localparam int SPW  = QB + SW;
  localparam int STW  = ((SPW + QB > TW) ? SPW + QB : TW) + 1;
  localparam int HSW  = HZW + SW;

  // Configuration register indexes
  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] CFG_HORIZON    = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_SCALE      = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_OWN_RADIUS = 2'd2;

  localparam logic [HZW-1:0] HORIZON_RST    = 16'd768;
  localparam logic [SCW-1:0] SCALE_RST      = 10'd282;
  localparam logic [RDW-1:0] OWN_RADIUS_RST = 16'd77;

  localparam logic signed [TQW-1:0] TQ_MAX = {1'b0, {(TQW-1){1'b1}}};
  localparam logic signed [TQW-1:0] TQ_MIN = {1'b1, {(TQW-1){1'b0}}};

  typedef struct packed {
    logic signed [CW-1:0] target_x;
    logic signed [CW-1:0] target_y;
    logic signed [VW-1:0] target_vx;
    logic signed [VW-1:0] target_vy;
    logic [RDW-1:0]       target_radius;
    logic [AGW-1:0]       track_age;
    logic signed [CW-1:0] own_x;
    logic signed [CW-1:0] own_y;
    logic signed [VW-1:0] own_vx;
    logic signed [VW-1:0] own_vy;
  } in_t;

  typedef struct packed {
    logic signed [CW-1:0]  pred_x;
    logic signed [CW-1:0]  pred_y;
    logic signed [TQW-1:0] time_to_cpa;
    logic                  cpa_infinite;
    logic [QB-1:0]         dist_at_cpa;
    logic                  overlap_now;
    logic                  threat;
  } out_t;

  typedef struct packed {
    logic inf;
    logic overlap;
    logic near;
    logic neg;
  } flags_t;

  // Divider and root recurrence state
  typedef struct packed {
    flags_t               flags;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic [QB-1:0]        q;
    logic [QRW-1:0]       drem;
    logic [DVW-1:0]       dvs;
    logic [TW-1:0]        srem;
    logic [SW-1:0]        sm;
    logic [SPW-1:0]       sp;
    logic [QB-1:0]        sd;
  } it_t;

  function automatic logic signed [CW-1:0] sat_coord(input logic signed [ESW-1:0] v);
    logic [ESW-CW:0] hi;
    hi = v[ESW-1:CW-1];
    if (hi == '0 || hi == '1) begin
      sat_coord = v[CW-1:0];
    end else if (v[ESW-1]) begin
      sat_coord = {1'b1, {(CW-1){1'b0}}};
    end else begin
      sat_coord = {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cpa_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cpa_front import cpa_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  in_t            in_item,
  input  logic [SCW-1:0] radius_scale,
  input  logic [RDW-1:0] own_radius,
  input  logic [HZW-1:0] tcpa_horizon,
  output logic           out_valid,
  output it_t            out_item
);

  logic [8:0] vld_r;

  // stage 1
  logic signed [PW-1:0] s1_pvx_nxt, s1_pvy_nxt, s1_pvx_r, s1_pvy_r;
  logic signed [UW-1:0] s1_ux_nxt, s1_uy_nxt, s1_ux_r, s1_uy_r;
  logic [LSW-1:0]       s1_rsum_nxt, s1_rsum_r;
  logic signed [CW-1:0] s1_tx_r, s1_ty_r, s1_ox_r, s1_oy_r;
  // stage 2
  logic signed [PW-1:0]  s2_shx, s2_shy;
  logic signed [ESW-1:0] s2_sx, s2_sy;
  logic signed [CW-1:0]  s2_px_nxt, s2_py_nxt, s2_px_r, s2_py_r, s2_ox_r, s2_oy_r;
  logic [SW-1:0]         s2_ux2_nxt, s2_uy2_nxt, s2_ux2_r, s2_uy2_r;
  logic [LW-1:0]         s2_lim_nxt, s2_lim_r;
  logic signed [UW-1:0]  s2_ux_r, s2_uy_r;
  // stage 3
  logic signed [RW-1:0] s3_rx_nxt, s3_ry_nxt, s3_rx_r, s3_ry_r;
  logic [SW-1:0]        s3_spd_nxt, s3_spd_r;
  logic [L2W-1:0]       s3_lim2_nxt, s3_lim2_r;
  logic signed [UW-1:0] s3_ux_r, s3_uy_r;
  logic signed [CW-1:0] s3_px_r, s3_py_r;
  // stage 4
  logic [RRW-1:0]        s4_rxrx_nxt, s4_ryry_nxt, s4_rxrx_r, s4_ryry_r;
  logic signed [DTW-1:0] s4_rxux_nxt, s4_ryuy_nxt, s4_rxuy_nxt, s4_ryux_nxt;
  logic signed [DTW-1:0] s4_rxux_r, s4_ryuy_r, s4_rxuy_r, s4_ryux_r;
  logic [HSW-1:0]        s4_hspd_nxt, s4_hspd_r;
  logic [LPW-1:0]        s4_llo_nxt, s4_lhi_nxt, s4_llo_r, s4_lhi_r;
  logic [SW-1:0]         s4_spd_r;
  logic [L2W-1:0]        s4_lim2_r;
  logic signed [CW-1:0]  s4_px_r, s4_py_r;
  // stage 5
  logic [D2W-1:0]        s5_d2_nxt, s5_d2_r;
  logic signed [DTW-1:0] s5_dot_nxt, s5_crs_nxt, s5_dot_r, s5_crs_r;
  logic [LSPW-1:0]       s5_lsp_nxt, s5_lsp_r;
  logic                  s5_inf_nxt, s5_inf_r;
  logic [SW-1:0]         s5_spd_r;
  logic [HSW-1:0]        s5_hspd_r;
  logic [L2W-1:0]        s5_lim2_r;
  logic signed [CW-1:0]  s5_px_r, s5_py_r;
  // stage 6
  logic                 s6_neg_nxt, s6_ovl_nxt, s6_neg_r, s6_ovl_r, s6_inf_r;
  logic [AW-1:0]        s6_adot, s6_acrs_nxt, s6_acrs_r;
  logic [NMW-1:0]       s6_nm_nxt, s6_nm_r;
  logic [D2W-1:0]       s6_d2_r;
  logic [SW-1:0]        s6_spd_r;
  logic [HSW-1:0]       s6_hspd_r;
  logic [LSPW-1:0]      s6_lsp_r;
  logic signed [CW-1:0] s6_px_r, s6_py_r;
  // stage 7
  logic                 s7_tw_nxt, s7_tw_r, s7_neg_r, s7_ovl_r, s7_inf_r;
  logic [NW-1:0]        s7_n_nxt, s7_n_r;
  logic [DVW-1:0]       s7_d_nxt, s7_d_r;
  logic [2*AH-1:0]      s7_a0a0_nxt, s7_a0a0_r;
  logic [2*(AW-AH)-1:0] s7_a1a1_nxt, s7_a1a1_r;
  logic [AW-1:0]        s7_a0a1_nxt, s7_a0a1_r;
  logic [D2W-1:0]       s7_d2_r;
  logic [SW-1:0]        s7_spd_r;
  logic [LSPW-1:0]      s7_lsp_r;
  logic signed [CW-1:0] s7_px_r, s7_py_r;
  // stage 8
  logic [TW-1:0]        s8_acsq_nxt, s8_acsq_r;
  logic                 s8_tw_r, s8_neg_r, s8_ovl_r, s8_inf_r;
  logic [NW-1:0]        s8_n_r;
  logic [DVW-1:0]       s8_d_r;
  logic [D2W-1:0]       s8_d2_r;
  logic [SW-1:0]        s8_spd_r;
  logic [LSPW-1:0]      s8_lsp_r;
  logic signed [CW-1:0] s8_px_r, s8_py_r;
  // stage 9
  it_t item_nxt, item_r;

  always_comb begin
    s1_pvx_nxt  = $signed(in_item.target_vx) * $signed({1'b0, in_item.track_age});
    s1_pvy_nxt  = $signed(in_item.target_vy) * $signed({1'b0, in_item.track_age});
    s1_ux_nxt   = $signed(in_item.target_vx) - $signed(in_item.own_vx);
    s1_uy_nxt   = $signed(in_item.target_vy) - $signed(in_item.own_vy);
    s1_rsum_nxt = LSW'(in_item.target_radius) + LSW'(own_radius);
  end

  // round half up to Q.8, add, saturate
  always_comb begin
    s2_shx     = (s1_pvx_r + $signed(PW'(128))) >>> 8;
    s2_shy     = (s1_pvy_r + $signed(PW'(128))) >>> 8;
    s2_sx      = s1_tx_r + $signed(s2_shx[ESW-1:0]);
    s2_sy      = s1_ty_r + $signed(s2_shy[ESW-1:0]);
    s2_px_nxt  = sat_coord(s2_sx);
    s2_py_nxt  = sat_coord(s2_sy);
    s2_ux2_nxt = s1_ux_r * s1_ux_r;
    s2_uy2_nxt = s1_uy_r * s1_uy_r;
    s2_lim_nxt = radius_scale * s1_rsum_r;
  end

  always_comb begin
    s3_rx_nxt   = s2_px_r - s2_ox_r;
    s3_ry_nxt   = s2_py_r - s2_oy_r;
    s3_spd_nxt  = s2_ux2_r + s2_uy2_r;
    s3_lim2_nxt = s2_lim_r * s2_lim_r;
  end

  always_comb begin
    s4_rxrx_nxt = s3_rx_r * s3_rx_r;
    s4_ryry_nxt = s3_ry_r * s3_ry_r;
    s4_rxux_nxt = s3_rx_r * s3_ux_r;
    s4_ryuy_nxt = s3_ry_r * s3_uy_r;
    s4_rxuy_nxt = s3_rx_r * s3_uy_r;
    s4_ryux_nxt = s3_ry_r * s3_ux_r;
    s4_hspd_nxt = tcpa_horizon * s3_spd_r;
    s4_llo_nxt  = s3_lim2_r[LW-1:0] * s3_spd_r;
    s4_lhi_nxt  = s3_lim2_r[L2W-1:LW] * s3_spd_r;
  end

  always_comb begin
    s5_d2_nxt  = D2W'(s4_rxrx_r) + D2W'(s4_ryry_r);
    s5_dot_nxt = s4_rxux_r + s4_ryuy_r;
    s5_crs_nxt = s4_rxuy_r - s4_ryux_r;
    s5_lsp_nxt = (LSPW'(s4_lhi_r) << LW) + LSPW'(s4_llo_r);
    s5_inf_nxt = (s4_spd_r == '0);
  end

  always_comb begin
    s6_neg_nxt  = (s5_dot_r > 0);
    s6_adot     = s5_dot_r[DTW-1] ? AW'(-s5_dot_r) : AW'(s5_dot_r);
    s6_acrs_nxt = s5_crs_r[DTW-1] ? AW'(-s5_crs_r) : AW'(s5_crs_r);
    s6_nm_nxt   = {s6_adot, 8'd0};
    s6_ovl_nxt  = ({s5_d2_r, 16'd0} <= s5_lim2_r);
  end

  // ac^2 split into half-width products
  always_comb begin
    s7_tw_nxt   = !s6_neg_r && (s6_nm_r <= s6_hspd_r);
    s7_n_nxt    = NW'({s6_nm_r, 1'b0}) + NW'(s6_spd_r);
    s7_d_nxt    = {s6_spd_r, 1'b0};
    s7_a0a0_nxt = s6_acrs_r[AH-1:0] * s6_acrs_r[AH-1:0];
    s7_a1a1_nxt = s6_acrs_r[AW-1:AH] * s6_acrs_r[AW-1:AH];
    s7_a0a1_nxt = s6_acrs_r[AH-1:0] * s6_acrs_r[AW-1:AH];
  end

  always_comb begin
    s8_acsq_nxt = (TW'(s7_a1a1_r) << (2 * AH)) + (TW'(s7_a0a1_r) << (AH + 1))
                + TW'(s7_a0a0_r);
  end

  always_comb begin
    item_nxt.flags.inf     = s8_inf_r;
    item_nxt.flags.overlap = s8_ovl_r;
    item_nxt.flags.near    = s8_tw_r && !s8_inf_r && ({s8_acsq_r, 16'd0} < s8_lsp_r);
    item_nxt.flags.neg     = s8_neg_r;
    item_nxt.px            = s8_px_r;
    item_nxt.py            = s8_py_r;
    item_nxt.q             = '0;
    item_nxt.drem          = QRW'(s8_n_r);
    item_nxt.dvs           = s8_d_r;
    item_nxt.srem          = s8_inf_r ? TW'(s8_d2_r) : s8_acsq_r;
    item_nxt.sm            = s8_inf_r ? SW'(1) : s8_spd_r;
    item_nxt.sp            = '0;
    item_nxt.sd            = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[7:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    s1_pvx_r  <= s1_pvx_nxt;
    s1_pvy_r  <= s1_pvy_nxt;
    s1_ux_r   <= s1_ux_nxt;
    s1_uy_r   <= s1_uy_nxt;
    s1_rsum_r <= s1_rsum_nxt;
    s1_tx_r   <= in_item.target_x;
    s1_ty_r   <= in_item.target_y;
    s1_ox_r   <= in_item.own_x;
    s1_oy_r   <= in_item.own_y;

    s2_px_r  <= s2_px_nxt;
    s2_py_r  <= s2_py_nxt;
    s2_ox_r  <= s1_ox_r;
    s2_oy_r  <= s1_oy_r;
    s2_ux2_r <= s2_ux2_nxt;
    s2_uy2_r <= s2_uy2_nxt;
    s2_lim_r <= s2_lim_nxt;
    s2_ux_r  <= s1_ux_r;
    s2_uy_r  <= s1_uy_r;

    s3_rx_r   <= s3_rx_nxt;
    s3_ry_r   <= s3_ry_nxt;
    s3_spd_r  <= s3_spd_nxt;
    s3_lim2_r <= s3_lim2_nxt;
    s3_ux_r   <= s2_ux_r;
    s3_uy_r   <= s2_uy_r;
    s3_px_r   <= s2_px_r;
    s3_py_r   <= s2_py_r;

    s4_rxrx_r <= s4_rxrx_nxt;
    s4_ryry_r <= s4_ryry_nxt;
    s4_rxux_r <= s4_rxux_nxt;
    s4_ryuy_r <= s4_ryuy_nxt;
    s4_rxuy_r <= s4_rxuy_nxt;
    s4_ryux_r <= s4_ryux_nxt;
    s4_hspd_r <= s4_hspd_nxt;
    s4_llo_r  <= s4_llo_nxt;
    s4_lhi_r  <= s4_lhi_nxt;
    s4_spd_r  <= s3_spd_r;
    s4_lim2_r <= s3_lim2_r;
    s4_px_r   <= s3_px_r;
    s4_py_r   <= s3_py_r;

    s5_d2_r   <= s5_d2_nxt;
    s5_dot_r  <= s5_dot_nxt;
    s5_crs_r  <= s5_crs_nxt;
    s5_lsp_r  <= s5_lsp_nxt;
    s5_inf_r  <= s5_inf_nxt;
    s5_spd_r  <= s4_spd_r;
    s5_hspd_r <= s4_hspd_r;
    s5_lim2_r <= s4_lim2_r;
    s5_px_r   <= s4_px_r;
    s5_py_r   <= s4_py_r;

    s6_neg_r  <= s6_neg_nxt;
    s6_ovl_r  <= s6_ovl_nxt;
    s6_inf_r  <= s5_inf_r;
    s6_acrs_r <= s6_acrs_nxt;
    s6_nm_r   <= s6_nm_nxt;
    s6_d2_r   <= s5_d2_r;
    s6_spd_r  <= s5_spd_r;
    s6_hspd_r <= s5_hspd_r;
    s6_lsp_r  <= s5_lsp_r;
    s6_px_r   <= s5_px_r;
    s6_py_r   <= s5_py_r;

    s7_tw_r   <= s7_tw_nxt;
    s7_neg_r  <= s6_neg_r;
    s7_ovl_r  <= s6_ovl_r;
    s7_inf_r  <= s6_inf_r;
    s7_n_r    <= s7_n_nxt;
    s7_d_r    <= s7_d_nxt;
    s7_a0a0_r <= s7_a0a0_nxt;
    s7_a1a1_r <= s7_a1a1_nxt;
    s7_a0a1_r <= s7_a0a1_nxt;
    s7_d2_r   <= s6_d2_r;
    s7_spd_r  <= s6_spd_r;
    s7_lsp_r  <= s6_lsp_r;
    s7_px_r   <= s6_px_r;
    s7_py_r   <= s6_py_r;

    s8_acsq_r <= s8_acsq_nxt;
    s8_tw_r   <= s7_tw_r;
    s8_neg_r  <= s7_neg_r;
    s8_ovl_r  <= s7_ovl_r;
    s8_inf_r  <= s7_inf_r;
    s8_n_r    <= s7_n_r;
    s8_d_r    <= s7_d_r;
    s8_d2_r   <= s7_d2_r;
    s8_spd_r  <= s7_spd_r;
    s8_lsp_r  <= s7_lsp_r;
    s8_px_r   <= s7_px_r;
    s8_py_r   <= s7_py_r;

    item_r <= item_nxt;
  end

  assign out_valid = vld_r[8];
  assign out_item  = item_r;

endmodule

`default_nettype wire

>>> hw/rtl/cpa_iter.sv
`timescale 1ns / 1ps
`default_nettype none

// One bit of the rounding divider and one bit of the root search.
module cpa_iter import cpa_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  it_t  in_item,
  output logic out_valid,
  output it_t  out_item
);

  localparam logic [QB-1:0] BIT_MASK = QB'(1) << BIT;

  logic [QRW-1:0] dtry;
  logic           dge;
  logic [STW-1:0] stry;
  logic           sge;
  it_t            item_nxt, item_r;
  logic           vld_r;

  always_comb begin
    dtry = QRW'(in_item.dvs) << BIT;
    dge  = (in_item.drem >= dtry);
    // (d + 2^b)^2 * m - d^2 * m
    stry = (STW'(in_item.sp) << (BIT + 1)) + (STW'(in_item.sm) << (2 * BIT));
    sge  = (STW'(in_item.srem) >= stry);
    item_nxt = in_item;
    if (dge) begin
      item_nxt.q    = in_item.q | BIT_MASK;
      item_nxt.drem = in_item.drem - dtry;
    end
    if (sge) begin
      item_nxt.sd   = in_item.sd | BIT_MASK;
      item_nxt.srem = in_item.srem - stry[TW-1:0];
      item_nxt.sp   = in_item.sp + (SPW'(in_item.sm) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_valid = vld_r;
  assign out_item  = item_r;

endmodule

`default_nettype wire

>>> hw/rtl/cpa_threat_assessment_core.sv
`timescale 1ns / 1ps
`default_nettype none

// A start beat passes through the front pipeline, the divider and root stages and the
// output register before out_valid rises with its result.
// Throughput: one item per cycle while busy is low; busy stays low once out of reset.
// The 24 bit-per-stage divider and root stages, with the front pipeline, set the depth.
// Reset (rst_n low, synchronous) clears all valid bits and loads the register defaults;
// busy is high during reset and until the first clock edge with rst_n high.

module cpa_threat_assessment_core import cpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_t               in_data,
  output logic              out_valid,
  output out_t              out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [HZW-1:0]    cfg_data
);

  logic           busy_r;
  logic [HZW-1:0] horizon_r;
  logic [SCW-1:0] scale_r;
  logic [RDW-1:0] own_radius_r;
  logic           accept;
  logic [QB:0]    chain_vld;
  it_t            chain [QB:0];
  flags_t         fl;
  logic [QB-1:0]  qv;
  out_t           res_nxt, out_r;
  logic           out_valid_r;

  assign cfg_ready = 1'b1;
  assign busy      = busy_r;
  assign accept    = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      horizon_r    <= HORIZON_RST;
      scale_r      <= SCALE_RST;
      own_radius_r <= OWN_RADIUS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HORIZON:    horizon_r    <= cfg_data;
        CFG_SCALE:      scale_r      <= cfg_data[SCW-1:0];
        CFG_OWN_RADIUS: own_radius_r <= cfg_data;
        default: ;
      endcase
    end
  end

  cpa_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (accept),
    .in_item      (in_data),
    .radius_scale (scale_r),
    .own_radius   (own_radius_r),
    .tcpa_horizon (horizon_r),
    .out_valid    (chain_vld[QB]),
    .out_item     (chain[QB])
  );

  // MSB first: stage g resolves bit g
  for (genvar g = 0; g < QB; g++) begin : g_iter
    cpa_iter #(.BIT(g)) u_iter (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_vld[g+1]),
      .in_item   (chain[g+1]),
      .out_valid (chain_vld[g]),
      .out_item  (chain[g])
    );
  end

  always_comb begin
    fl = chain[0].flags;
    qv = chain[0].q;
    res_nxt.pred_x       = chain[0].px;
    res_nxt.pred_y       = chain[0].py;
    res_nxt.cpa_infinite = fl.inf;
    res_nxt.dist_at_cpa  = chain[0].sd;
    res_nxt.overlap_now  = fl.overlap;
    res_nxt.threat       = fl.overlap || fl.near;
    // top quotient bit set means the magnitude is out of range: saturate
    if (fl.inf) begin
      res_nxt.time_to_cpa = '0;
    end else if (qv[QB-1]) begin
      res_nxt.time_to_cpa = fl.neg ? TQ_MIN : TQ_MAX;
    end else begin
      res_nxt.time_to_cpa = fl.neg ? (TQW'(0) - qv) : qv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain_vld[0];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_chain_latency: assert property (@(posedge clk) disable iff (!rst_n)
    chain_vld[QB] |-> ##QB chain_vld[0])
    else $error("recurrence stages dropped a beat");

  a_inf_zero_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.cpa_infinite |-> out_r.time_to_cpa == '0)
    else $error("infinite TCPA with nonzero time");

  a_overlap_threat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.overlap_now |-> out_r.threat)
    else $error("overlap without threat");

  a_busy_low: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy_r)
    else $error("busy high after reset");
`endif

endmodule

`default_nettype wire

>>> tb/cpa_threat_assessment_core_tb.sv
`timescale 1ns / 1ps

module cpa_threat_assessment_core_tb;
  import cpa_pkg::*;

  // index with no register behind it
  localparam logic [CFG_IW-1:0] CFG_NONE = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  in_t               in_data = '0;
  logic              out_valid;
  out_t              out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index = CFG_HORIZON;
  logic [HZW-1:0]    cfg_data = '0;

  // shadow copies of the block's registers
  logic [HZW-1:0] horizon_q = HORIZON_RST;
  logic [SCW-1:0] scale_q   = SCALE_RST;
  logic [RDW-1:0] own_rad_q = OWN_RADIUS_RST;

  int unsigned n_items = 0;
  int unsigned n_threats = 0;
  int unsigned n_infinite = 0;

  always #5 clk = ~clk;

  cpa_threat_assessment_core DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  class cpa_scoreboard;
    out_t pending_q[$];
    int   errors = 0;

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void note(out_t e);
      pending_q = {pending_q, e};
    endfunction

    task check(out_t got);
      out_t e;
      if (pending_q.size() == 0) begin
        report("result beat with nothing pending");
        return;
      end
      e = pending_q.pop_front();
      if (got.pred_x !== e.pred_x)
        report($sformatf("pred_x got %h exp %h", got.pred_x, e.pred_x));
      if (got.pred_y !== e.pred_y)
        report($sformatf("pred_y got %h exp %h", got.pred_y, e.pred_y));
      if (got.time_to_cpa !== e.time_to_cpa)
        report($sformatf("time_to_cpa got %h exp %h", got.time_to_cpa, e.time_to_cpa));
      if (got.cpa_infinite !== e.cpa_infinite)
        report($sformatf("cpa_infinite got %b exp %b", got.cpa_infinite, e.cpa_infinite));
      if (got.dist_at_cpa !== e.dist_at_cpa)
        report($sformatf("dist_at_cpa got %h exp %h", got.dist_at_cpa, e.dist_at_cpa));
      if (got.overlap_now !== e.overlap_now)
        report($sformatf("overlap_now got %b exp %b", got.overlap_now, e.overlap_now));
      if (got.threat !== e.threat)
        report($sformatf("threat got %b exp %b", got.threat, e.threat));
    endtask
  endclass

  cpa_scoreboard sb = new();

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // largest d below 2^24 with d*d*m <= tgt
  function automatic logic [QB-1:0] isqrt_floor(logic [127:0] tgt, logic [127:0] m);
    logic [63:0] lo, hi, mid;
    lo = '0;
    hi = 64'hFFFFFF;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 64'd1) >> 1);
      if ({64'd0, mid * mid} * m <= tgt) lo = mid;
      else hi = mid - 64'd1;
    end
    return lo[QB-1:0];
  endfunction

  function automatic out_t assess(in_t d);
    longint cmax, cmin, tvx, tvy, age, trad, ovx, ovy, px, py;
    longint rx, ry, ux, uy, spd, d2, lim, dot, crs, num, nm, q, tq, ac;
    logic [127:0] wd2, wl, wspd, wac;
    logic [QB-1:0] dq;
    logic ovl, inf, near;
    out_t r;
    cmax = (longint'(1) <<< (CW - 1)) - 1;
    cmin = -cmax - 1;
    tvx = longint'(d.target_vx);
    tvy = longint'(d.target_vy);
    ovx = longint'(d.own_vx);
    ovy = longint'(d.own_vy);
    age = longint'({1'b0, d.track_age});
    trad = longint'({1'b0, d.target_radius});
    px = clamp(longint'(d.target_x) + ((tvx * age + 128) >>> 8), cmin, cmax);
    py = clamp(longint'(d.target_y) + ((tvy * age + 128) >>> 8), cmin, cmax);
    rx = px - longint'(d.own_x);
    ry = py - longint'(d.own_y);
    ux = tvx - ovx;
    uy = tvy - ovy;
    spd = ux * ux + uy * uy;
    d2 = rx * rx + ry * ry;
    lim = longint'({1'b0, scale_q}) * (longint'({1'b0, own_rad_q}) + trad);
    wd2 = 128'(d2);
    wl = 128'(lim);
    wspd = 128'(spd);
    ovl = (wd2 << 16) <= wl * wl;
    inf = (spd == 0);
    tq = 0;
    near = 1'b0;
    if (inf) begin
      dq = isqrt_floor(wd2, 128'd1);
    end else begin
      dot = rx * ux + ry * uy;
      crs = rx * uy - ry * ux;
      num = -dot * 256;
      nm = num < 0 ? -num : num;
      q = (2 * nm + spd) / (2 * spd);
      tq = clamp(num < 0 ? -q : q, -8388608, 8388607);
      ac = crs < 0 ? -crs : crs;
      wac = 128'(ac);
      dq = isqrt_floor(wac * wac, wspd);
      near = dot <= 0 && num <= longint'({1'b0, horizon_q}) * spd &&
             ((wac << 8) * (wac << 8) < wl * wl * wspd);
    end
    r.pred_x = px[CW-1:0];
    r.pred_y = py[CW-1:0];
    r.time_to_cpa = tq[TQW-1:0];
    r.cpa_infinite = inf;
    r.dist_at_cpa = dq;
    r.overlap_now = ovl;
    r.threat = ovl | near;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check(out_data);
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // drive one beat; start stays high when the next beat follows directly
  task send(in_t d, int unsigned gap);
    out_t e;
    in_data <= d;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    e = assess(d);
    sb.note(e);
    n_items++;
    if (e.threat) n_threats++;
    if (e.cpa_infinite) n_infinite++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task drain();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task write_reg(logic [CFG_IW-1:0] idx, logic [HZW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_HORIZON:    horizon_q = val;
      CFG_SCALE:      scale_q = val[SCW-1:0];
      CFG_OWN_RADIUS: own_rad_q = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [31:0] edge_val(int unsigned w);
    case ($urandom_range(0, 4))
      0: return 32'h1 << (w - 1);
      1: return (32'h1 << (w - 1)) - 32'h1;
      2: return 32'h0;
      3: return {32{1'b1}};
      default: return $urandom();
    endcase
  endfunction

  function automatic in_t rand_item();
    in_t d;
    int k;
    logic [15:0] ox, oy;
    k = int'($urandom_range(0, 9));
    d = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    if (k >= 3 && k <= 7) begin
      // close encounter with modest speeds so the threat window is reachable
      ox = 16'($urandom_range(0, 8191) - 4096);
      oy = 16'($urandom_range(0, 8191) - 4096);
      d.target_x = d.own_x + CW'(signed'(ox));
      d.target_y = d.own_y + CW'(signed'(oy));
      d.target_vx = VW'($urandom_range(0, 2047) - 1024);
      d.target_vy = VW'($urandom_range(0, 2047) - 1024);
      d.own_vx = VW'($urandom_range(0, 2047) - 1024);
      d.own_vy = VW'($urandom_range(0, 2047) - 1024);
      d.track_age = AGW'($urandom_range(0, 1023));
      d.target_radius = RDW'($urandom_range(0, 1535));
      if (k == 7) begin
        d.own_vx = d.target_vx;
        d.own_vy = d.target_vy;
      end
    end else if (k == 8) begin
      d.target_x = CW'(edge_val(CW));
      d.target_y = CW'(edge_val(CW));
      d.target_vx = VW'(edge_val(VW));
      d.target_vy = VW'(edge_val(VW));
      d.target_radius = RDW'(edge_val(RDW));
      d.track_age = AGW'(edge_val(AGW));
      d.own_x = CW'(edge_val(CW));
      d.own_y = CW'(edge_val(CW));
      d.own_vx = VW'(edge_val(VW));
      d.own_vy = VW'(edge_val(VW));
    end else if (k == 9) begin
      // head-on: relative velocity points back along the offset
      ox = 16'($urandom_range(0, 2047) - 1024);
      oy = 16'($urandom_range(0, 2047) - 1024);
      d.track_age = '0;
      d.target_x = d.own_x + CW'(signed'(ox));
      d.target_y = d.own_y + CW'(signed'(oy));
      d.own_vx = VW'($urandom_range(0, 1023) - 512);
      d.own_vy = VW'($urandom_range(0, 1023) - 512);
      d.target_vx = VW'(d.own_vx - signed'(ox) + $urandom_range(0, 8) - 4);
      d.target_vy = VW'(d.own_vy - signed'(oy) + $urandom_range(0, 8) - 4);
      d.target_radius = RDW'($urandom_range(0, 512));
    end
    return d;
  endfunction

  task run_random(int unsigned n);
    bit burst;
    burst = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 100 == 0) burst = ($urandom_range(0, 2) == 0);
      send(rand_item(), burst ? 0 : pick_gap());
    end
    start <= 1'b0;
    drain();
  endtask

  task run_directed();
    in_t d;
    // zero relative velocity, both at rest at the origin: overlap
    d = '0;
    send(d, 0);
    // extreme coordinates and velocities, pushing prediction into saturation
    d = '0;
    d.target_x = {1'b0, {(CW-1){1'b1}}};
    d.target_y = {1'b1, {(CW-1){1'b0}}};
    d.target_vx = 16'sh7FFF;
    d.target_vy = 16'sh8000;
    d.track_age = 16'hFFFF;
    send(d, 1);
    d.own_x = {1'b1, {(CW-1){1'b0}}};
    d.own_y = {1'b0, {(CW-1){1'b1}}};
    d.own_vx = 16'sh8000;
    d.own_vy = 16'sh7FFF;
    d.target_radius = 16'hFFFF;
    send(d, 0);
    // equal nonzero velocities: infinite TCPA away from overlap
    d = '0;
    d.target_x = 24'sd5000;
    d.target_vx = 16'sd300;
    d.own_vx = 16'sd300;
    send(d, 0);
    // smallest nonzero relative velocity
    d = '0;
    d.target_x = 24'sd1000;
    d.target_vx = -16'sd1;
    send(d, 2);
    d.target_vy = 16'sd1;
    d.target_vx = 16'sd0;
    send(d, 0);
    // approaching head-on, inside horizon
    d = '0;
    d.target_x = 24'sd512;
    d.target_vx = -16'sd256;
    d.target_radius = 16'd100;
    send(d, 0);
    // receding: negative TCPA
    d.target_vx = 16'sd256;
    send(d, 0);
    // crossing with a miss
    d = '0;
    d.target_x = 24'sd512;
    d.target_y = 24'sd300;
    d.target_vx = -16'sd256;
    send(d, 3);
    // all ones everywhere
    d = '1;
    send(d, 0);
    // alternating bit patterns
    d = {$bits(in_t)/2{2'b10}};
    send(d, 0);
    d = {$bits(in_t)/2{2'b01}};
    send(d, 0);
    // huge TCPA: far away, tiny closing speed
    d = '0;
    d.target_x = {1'b0, {(CW-1){1'b1}}};
    d.target_vx = -16'sd1;
    d.own_x = {1'b1, {(CW-1){1'b0}}};
    send(d, 0);
    d.target_vx = 16'sd1;
    send(d, 0);
    start <= 1'b0;
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    run_directed();
    run_random(400);
    write_reg(CFG_HORIZON, 16'd0);
    write_reg(CFG_SCALE, 16'd256);
    write_reg(CFG_OWN_RADIUS, 16'd0);
    run_random(400);
    write_reg(CFG_HORIZON, 16'hFFFF);
    write_reg(CFG_SCALE, 16'd1023);
    write_reg(CFG_OWN_RADIUS, 16'hFFFF);
    run_random(400);
    // unused index must leave the registers alone
    write_reg(CFG_NONE, 16'h1234);
    run_random(200);
    write_reg(CFG_HORIZON, HZW'($urandom_range(0, 4096)));
    write_reg(CFG_SCALE, HZW'($urandom_range(256, 1023)));
    write_reg(CFG_OWN_RADIUS, HZW'($urandom_range(0, 2048)));
    run_random(400);
    write_reg(CFG_HORIZON, HZW'($urandom()));
    write_reg(CFG_SCALE, HZW'($urandom_range(256, 1023)));
    write_reg(CFG_OWN_RADIUS, HZW'($urandom()));
    run_random(200);
    if (sb.pending_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_q.size()));
    $display("Covered %0d targets under five register settings:", n_items);
    $display("  %0d threats, %0d infinite TCPA.", n_threats, n_infinite);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d results pending", sb.pending_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
